// File: hdl/tdor_pkg.sv
// ----------------------------------------------------------------------------
// tdor_pkg
// Types, codes and command/status bundles shared by the route expander.
// ----------------------------------------------------------------------------
package tdor_pkg;

    localparam int DIMS    = 5;
    localparam int ORDER_W = 3;
    localparam int ID_W    = 15;
    localparam int WT_W    = 16;
    localparam int TDATA_W = 32;
    localparam int CFG_W   = 15;
    localparam int REG_IDX_W = 3;

    typedef logic [3:0]        dsize_t;
    typedef logic [2:0]        coord_t;
    typedef logic [ORDER_W-1:0] dim_t;
    typedef logic [WT_W-1:0]   wt_t;
    typedef logic [ID_W-1:0]   node_t;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_A      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_B      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_C      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_D      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_E      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TORUS_MASK  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROUTE_ORDER = 3'd6;

    localparam dsize_t           SIZE_RESET  = 4'd8;
    localparam logic [DIMS-1:0]  TORUS_RESET = 5'd31;
    localparam logic [CFG_W-1:0] ORDER_RESET = 15'd18056;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_WEIGHT = 3'd2;
    localparam logic [2:0] OP_SPLIT  = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;
    localparam logic [2:0] OP_HOP    = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] idx;
        logic [1:0] bit_idx;
    } tdor_cmd_t;

    typedef struct packed {
        logic bad;
        logic sel_active;
        logic out_free;
        logic arrive;
    } tdor_status_t;

endpackage

// File: hdl/torus_dimension_order_route_arcs_top.sv
// ----------------------------------------------------------------------------
// torus_dimension_order_route_arcs_top
// Dimension-order route expander for a five-dimensional mesh or torus.
// ----------------------------------------------------------------------------
// Each source/destination transaction expands into one result per link
// crossed, routed dimension by dimension in the programmed order, with tlast
// on the final hop. The block works on one transaction at a time: it
// accepts it, then runs place-weight multiplication, a range check and a
// bit-serial coordinate split (three quotient bits per dimension, both ids
// in parallel), then a select step per route-order entry and a hop step per
// hop, at most 35 hops; the result channel can stall a hop.
// Equal ids or ids outside the grid end at the range check with no result.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module torus_dimension_order_route_arcs_top
    import tdor_pkg::*;
#(
    parameter int DIM_COUNT    = 5,
    parameter int MAX_DIM_SIZE = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // src_node[14:0], dst_node[29:15]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // from_node[14:0], to_node[29:15]
    output logic                 m_tlast
);

    dsize_t           eff_size [DIMS];
    logic [DIMS-1:0]  torus_mask;
    logic [CFG_W-1:0] route_order;
    tdor_cmd_t        cmd;
    tdor_status_t     status;

    tdor_cfg #(
        .DIM_COUNT    (DIM_COUNT),
        .MAX_DIM_SIZE (MAX_DIM_SIZE)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .eff_size     (eff_size),
        .torus_mask   (torus_mask),
        .route_order  (route_order)
    );

    tdor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdor_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .eff_size    (eff_size),
        .torus_mask  (torus_mask),
        .route_order (route_order),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hdl/tdor_cfg.sv
// ----------------------------------------------------------------------------
// tdor_cfg
// Configuration registers and effective dimension sizes.
// ----------------------------------------------------------------------------
module tdor_cfg
    import tdor_pkg::*;
#(
    parameter int DIM_COUNT    = 5,
    parameter int MAX_DIM_SIZE = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    output dsize_t               eff_size [DIMS],
    output logic [DIMS-1:0]      torus_mask,
    output logic [CFG_W-1:0]     route_order
);

    dsize_t           size_reg [DIMS];
    logic [DIMS-1:0]  torus_mask_reg;
    logic [CFG_W-1:0] route_order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIMS; k++) begin
                size_reg[k] <= SIZE_RESET;
            end
            torus_mask_reg  <= TORUS_RESET;
            route_order_reg <= ORDER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SIZE_A:      size_reg[0] <= cfg_wr_data[3:0];
                REG_SIZE_B:      size_reg[1] <= cfg_wr_data[3:0];
                REG_SIZE_C:      size_reg[2] <= cfg_wr_data[3:0];
                REG_SIZE_D:      size_reg[3] <= cfg_wr_data[3:0];
                REG_SIZE_E:      size_reg[4] <= cfg_wr_data[3:0];
                REG_TORUS_MASK:  torus_mask_reg <= cfg_wr_data[DIMS-1:0];
                REG_ROUTE_ORDER: route_order_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            if (k >= DIM_COUNT || size_reg[k] == 4'd0) begin
                eff_size[k] = 4'd1;
            end else if (size_reg[k] > 4'(MAX_DIM_SIZE)) begin
                eff_size[k] = 4'(MAX_DIM_SIZE);
            end else begin
                eff_size[k] = size_reg[k];
            end
        end
    end

    assign torus_mask  = torus_mask_reg;
    assign route_order = route_order_reg;

endmodule

// File: hdl/tdor_ctrl.sv
// ----------------------------------------------------------------------------
// tdor_ctrl
// Sequencer: weights, range check, coordinate split, per-dimension hops.
// ----------------------------------------------------------------------------
module tdor_ctrl
    import tdor_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  tdor_status_t status,
    output tdor_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WEIGHT = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_SELECT = 3'd4;
    localparam logic [2:0] S_HOP    = 3'd5;

    localparam logic [2:0] LAST_DIM = 3'(DIMS - 1);

    logic [2:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] bit_reg, bit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        bit_next    = bit_reg;
        s_tready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.idx     = idx_reg;
        cmd.bit_idx = bit_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_WEIGHT;
                    idx_next   = LAST_DIM;
                end
            end
            S_WEIGHT: begin
                cmd.op = OP_WEIGHT;
                if (idx_reg == 3'd0) begin
                    state_next = S_CHECK;
                end else begin
                    idx_next = idx_reg - 3'd1;
                end
            end
            S_CHECK: begin
                if (status.bad) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SPLIT;
                    idx_next   = 3'd0;
                    bit_next   = 2'd2;
                end
            end
            S_SPLIT: begin
                cmd.op = OP_SPLIT;
                if (bit_reg == 2'd0) begin
                    bit_next = 2'd2;
                    if (idx_reg == LAST_DIM) begin
                        state_next = S_SELECT;
                        idx_next   = 3'd0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end else begin
                    bit_next = bit_reg - 2'd1;
                end
            end
            S_SELECT: begin
                cmd.op = OP_SELECT;
                if (status.sel_active) begin
                    state_next = S_HOP;
                end else if (idx_reg == LAST_DIM) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_HOP: begin
                cmd.op = OP_HOP;
                if (status.out_free && status.arrive) begin
                    if (idx_reg == LAST_DIM) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_SELECT;
                        idx_next   = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/tdor_dp.sv
// ----------------------------------------------------------------------------
// tdor_dp
// Datapath: place weights, bit-serial coordinate split, hop stepping and
// the result register.
// ----------------------------------------------------------------------------
module tdor_dp
    import tdor_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  tdor_cmd_t           cmd,
    output tdor_status_t        status,
    input  dsize_t              eff_size [DIMS],
    input  logic [DIMS-1:0]     torus_mask,
    input  logic [CFG_W-1:0]    route_order,
    input  logic [TDATA_W-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tlast
);

    node_t  src_id_reg, dst_id_reg, cur_id_reg;
    wt_t    acc_reg;
    wt_t    w_reg [DIMS];
    wt_t    span_reg [DIMS];
    wt_t    rem_src_reg, rem_dst_reg;
    coord_t cur_c_reg [DIMS];
    coord_t dst_c_reg [DIMS];

    dim_t   dim_reg;
    coord_t coord_reg, dc_reg;
    dsize_t n_reg;
    wt_t    w_sel_reg, span_sel_reg;
    logic   up_reg;

    logic   m_tvalid_reg;
    node_t  from_reg, to_reg;
    logic   last_reg;

    dim_t   order_dim [DIMS];
    dim_t   sel_dim;
    logic [2:0] sel_k;
    logic [2:0] w_addr;
    wt_t    w_rd;
    logic [19:0] prod;
    logic [17:0] trial;
    logic   ge_src, ge_dst;
    logic [7:0] diff;
    logic [DIMS-1:0] later;
    coord_t s_c, d_c, coord_gap;
    dsize_t half;
    logic   direct;
    logic   wrap;
    coord_t next_c;
    wt_t    cur_ext, next_id;
    logic   hop_fire;

    always_comb begin
        for (int q = 0; q < DIMS; q++) begin
            order_dim[q] = route_order[q*ORDER_W +: ORDER_W];
        end
    end

    assign sel_dim = order_dim[cmd.idx];
    assign sel_k   = (sel_dim < 3'(DIMS)) ? sel_dim : 3'd0;
    assign w_addr  = (cmd.op == OP_SPLIT) ? cmd.idx : sel_k;
    assign w_rd    = w_reg[w_addr];

    assign prod = {4'd0, acc_reg} * {16'd0, eff_size[cmd.idx]};

    assign trial  = {2'd0, w_rd} << cmd.bit_idx;
    assign ge_src = {2'd0, rem_src_reg} >= trial;
    assign ge_dst = {2'd0, rem_dst_reg} >= trial;

    always_comb begin
        diff = '0;
        for (int k = 0; k < DIMS; k++) begin
            diff[k] = cur_c_reg[k] != dst_c_reg[k];
        end
        for (int q = 0; q < DIMS; q++) begin
            later[q] = (3'(q) > cmd.idx) && (order_dim[q] != dim_reg) &&
                       diff[order_dim[q]];
        end
    end

    assign s_c       = cur_c_reg[sel_k];
    assign d_c       = dst_c_reg[sel_k];
    assign coord_gap = (s_c < d_c) ? d_c - s_c : s_c - d_c;
    assign half      = eff_size[sel_k] >> 1;
    assign direct    = !torus_mask[sel_k] || ({1'b0, coord_gap} < half) ||
                       ({1'b0, coord_gap} == half && !s_c[0]);

    assign wrap = up_reg ? ({1'b0, coord_reg} == n_reg - 4'd1) : (coord_reg == 3'd0);

    always_comb begin
        cur_ext = {1'b0, cur_id_reg};
        if (up_reg) begin
            next_c  = wrap ? 3'd0 : coord_reg + 3'd1;
            next_id = wrap ? cur_ext + w_sel_reg - span_sel_reg : cur_ext + w_sel_reg;
        end else begin
            next_c  = wrap ? 3'(n_reg - 4'd1) : coord_reg - 3'd1;
            next_id = wrap ? cur_ext + span_sel_reg - w_sel_reg : cur_ext - w_sel_reg;
        end
    end

    assign status.bad        = (src_id_reg == dst_id_reg) ||
                               ({1'b0, src_id_reg} >= acc_reg) ||
                               ({1'b0, dst_id_reg} >= acc_reg);
    assign status.sel_active = diff[sel_dim];
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.arrive     = next_c == dc_reg;

    assign hop_fire = (cmd.op == OP_HOP) && status.out_free;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                src_id_reg  <= s_tdata[ID_W-1:0];
                dst_id_reg  <= s_tdata[2*ID_W-1:ID_W];
                cur_id_reg  <= s_tdata[ID_W-1:0];
                rem_src_reg <= {1'b0, s_tdata[ID_W-1:0]};
                rem_dst_reg <= {1'b0, s_tdata[2*ID_W-1:ID_W]};
                acc_reg     <= 16'd1;
            end
            OP_WEIGHT: begin
                w_reg[cmd.idx]    <= acc_reg;
                span_reg[cmd.idx] <= prod[WT_W-1:0];
                acc_reg           <= prod[WT_W-1:0];
            end
            OP_SPLIT: begin
                cur_c_reg[cmd.idx][cmd.bit_idx] <= ge_src;
                dst_c_reg[cmd.idx][cmd.bit_idx] <= ge_dst;
                if (ge_src) begin
                    rem_src_reg <= 16'({2'd0, rem_src_reg} - trial);
                end
                if (ge_dst) begin
                    rem_dst_reg <= 16'({2'd0, rem_dst_reg} - trial);
                end
            end
            OP_SELECT: begin
                dim_reg      <= sel_dim;
                coord_reg    <= s_c;
                dc_reg       <= d_c;
                n_reg        <= eff_size[sel_k];
                w_sel_reg    <= w_rd;
                span_sel_reg <= span_reg[sel_k];
                up_reg       <= (s_c < d_c) == direct;
            end
            OP_HOP: begin
                if (hop_fire) begin
                    coord_reg          <= next_c;
                    cur_c_reg[dim_reg] <= next_c;
                    cur_id_reg         <= next_id[ID_W-1:0];
                    from_reg           <= cur_id_reg;
                    to_reg             <= next_id[ID_W-1:0];
                    last_reg           <= status.arrive && !(|later);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (hop_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W - 2*ID_W){1'b0}}, to_reg, from_reg};
    assign m_tlast  = last_reg;

endmodule
